/* rtl/psm_pkg.sv */
`timescale 1ns / 1ps
// Package for the PSK sine modulator: shared types, register indexes, phase codes
// and the elaboration-time sine table generator. No dependencies.
package psm_pkg;

  localparam int unsigned SPS_W  = 7;
  localparam int unsigned STEP_W = 16;
  localparam int unsigned IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_MODE_QPSK = 2'd0;
  localparam logic [IDX_W-1:0] REG_SPS       = 2'd1;
  localparam logic [IDX_W-1:0] REG_STEP      = 2'd2;

  localparam logic [SPS_W-1:0]  SPS_RESET  = 7'd64;
  localparam logic [STEP_W-1:0] STEP_RESET = 16'd2048;

  localparam logic [1:0] PH_ZERO       = 2'd0;
  localparam logic [1:0] PH_HALF_PI    = 2'd1;
  localparam logic [1:0] PH_PI         = 2'd2;
  localparam logic [1:0] PH_THREE_HALF = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } psm_state_t;

  typedef struct packed {
    logic       load;
    logic       emit;
    logic [1:0] quarter;
  } psm_cmd_t;

  typedef struct packed {
    logic out_free;
    logic last;
  } psm_status_t;

  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  function automatic longint unsigned psm_horner(longint unsigned sub);
    return (sub > Q30_ONE) ? 64'd0 : (Q30_ONE - sub);
  endfunction

  // Magnitude of quarter-wave entry r: sine, or cosine for odd quadrants
  function automatic longint unsigned psm_quarter_entry(longint unsigned r, bit use_cos,
                                                        int unsigned qb,
                                                        int unsigned sample_bits);
    longint unsigned a;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned v;
    longint unsigned amp;
    longint unsigned mag;
    amp = (64'd1 << (sample_bits - 1)) - 64'd1;
    a   = (r * HALF_PI_Q30) >> qb;
    x2  = (a * a) >> 30;
    t   = Q30_ONE;
    if (use_cos) begin
      t = psm_horner(((x2 * t) >> 30) / 64'd182);
      t = psm_horner(((x2 * t) >> 30) / 64'd132);
      t = psm_horner(((x2 * t) >> 30) / 64'd90);
      t = psm_horner(((x2 * t) >> 30) / 64'd56);
      t = psm_horner(((x2 * t) >> 30) / 64'd30);
      t = psm_horner(((x2 * t) >> 30) / 64'd12);
      t = psm_horner(((x2 * t) >> 30) / 64'd2);
      v = t;
    end else begin
      t = psm_horner(((x2 * t) >> 30) / 64'd156);
      t = psm_horner(((x2 * t) >> 30) / 64'd110);
      t = psm_horner(((x2 * t) >> 30) / 64'd72);
      t = psm_horner(((x2 * t) >> 30) / 64'd42);
      t = psm_horner(((x2 * t) >> 30) / 64'd20);
      t = psm_horner(((x2 * t) >> 30) / 64'd6);
      v = (a * t) >> 30;
    end
    mag = (v * amp + (64'd1 << 29)) >> 30;
    if (mag > amp) begin
      mag = amp;
    end
    return mag;
  endfunction

endpackage

/* rtl/psm_ctrl.sv */
`timescale 1ns / 1ps
// Controller for the PSK sine modulator: input handshake, QPSK bit pairing and symbol sequencing.
// Depends on psm_pkg.
module psm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  bit_in,
  input  logic                  mode_qpsk,
  input  psm_pkg::psm_status_t  status,
  output psm_pkg::psm_cmd_t     cmd
);

  psm_pkg::psm_state_t state;
  psm_pkg::psm_state_t state_next;
  logic held_bit;
  logic held_bit_next;
  logic held_valid;
  logic held_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= psm_pkg::ST_IDLE;
      held_bit   <= 1'b0;
      held_valid <= 1'b0;
    end else begin
      state      <= state_next;
      held_bit   <= held_bit_next;
      held_valid <= held_valid_next;
    end
  end

  always_comb begin
    state_next      = state;
    held_bit_next   = held_bit;
    held_valid_next = held_valid;
    in_stall        = 1'b1;
    cmd.load        = 1'b0;
    cmd.emit        = 1'b0;
    cmd.quarter     = psm_pkg::PH_ZERO;
    case (state)
      psm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (!mode_qpsk) begin
            held_valid_next = 1'b0;
            cmd.load        = 1'b1;
            cmd.quarter     = bit_in ? psm_pkg::PH_PI : psm_pkg::PH_ZERO;
            state_next      = psm_pkg::ST_RUN;
          end else if (!held_valid) begin
            held_bit_next   = bit_in;
            held_valid_next = 1'b1;
          end else begin
            held_valid_next = 1'b0;
            cmd.load        = 1'b1;
            if (!held_bit) begin
              cmd.quarter = bit_in ? psm_pkg::PH_PI : psm_pkg::PH_ZERO;
            end else begin
              cmd.quarter = bit_in ? psm_pkg::PH_HALF_PI : psm_pkg::PH_THREE_HALF;
            end
            state_next = psm_pkg::ST_RUN;
          end
        end
      end
      psm_pkg::ST_RUN: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.last) begin
            state_next = psm_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = psm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/psm_datapath.sv */
`timescale 1ns / 1ps
// Datapath for the PSK sine modulator: phase accumulator, sample counter, quarter-wave sine
// tables and output register. Depends on psm_pkg.
module psm_datapath #(
  parameter int MAX_SAMPLES     = 64,
  parameter int PHASE_BITS      = 16,
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  psm_pkg::psm_cmd_t             cmd,
  output psm_pkg::psm_status_t          status,
  input  logic [psm_pkg::SPS_W-1:0]     samples_per_symbol,
  input  logic [psm_pkg::STEP_W-1:0]    phase_step,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          last_of_symbol
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int QB = SINE_TABLE_BITS - 2;
  localparam int QN = 2 ** QB;
  localparam int MW = SAMPLE_BITS - 1;

  logic [PHASE_BITS-1:0]      acc;
  logic [CW-1:0]              remaining;
  logic [CW-1:0]              count_eff;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [1:0]                 quad;
  logic [QB-1:0]              rom_addr;
  logic [MW-1:0]              sin_rom [QN];
  logic [MW-1:0]              cos_rom [QN];
  logic [MW-1:0]              mag;
  logic [SAMPLE_BITS-1:0]     mag_ext;
  logic [SAMPLE_BITS-1:0]     sample_next;

  for (genvar k = 0; k < QN; k++) begin : g_rom
    assign sin_rom[k] = MW'(psm_pkg::psm_quarter_entry(k, 1'b0, QB, SAMPLE_BITS));
    assign cos_rom[k] = MW'(psm_pkg::psm_quarter_entry(k, 1'b1, QB, SAMPLE_BITS));
  end

  if (PHASE_BITS >= SINE_TABLE_BITS) begin : g_idx_shr
    assign idx = acc[PHASE_BITS-1 -: SINE_TABLE_BITS];
  end else begin : g_idx_shl
    assign idx = {acc, (SINE_TABLE_BITS - PHASE_BITS)'(0)};
  end

  always_comb begin
    if (samples_per_symbol == '0) begin
      count_eff = CW'(1);
    end else if (samples_per_symbol > psm_pkg::SPS_W'(MAX_SAMPLES)) begin
      count_eff = CW'(MAX_SAMPLES);
    end else begin
      count_eff = CW'(samples_per_symbol);
    end
  end

  assign quad        = idx[SINE_TABLE_BITS-1 -: 2];
  assign rom_addr    = idx[QB-1:0];
  assign mag         = quad[0] ? cos_rom[rom_addr] : sin_rom[rom_addr];
  assign mag_ext     = {1'b0, mag};
  assign sample_next = quad[1] ? (~mag_ext + SAMPLE_BITS'(1)) : mag_ext;

  assign status.out_free = !out_valid || !out_stall;
  assign status.last     = (remaining == CW'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc       <= {cmd.quarter, (PHASE_BITS - 2)'(0)};
      remaining <= count_eff;
    end else if (cmd.emit) begin
      acc       <= acc + PHASE_BITS'(phase_step);
      remaining <= remaining - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      sample         <= sample_next;
      last_of_symbol <= status.last;
    end
  end

`ifndef SYNTH
  a_emit_counts: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> remaining != '0)
    else $error("sample emitted with no samples left");
  a_load_count: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> remaining != '0)
    else $error("symbol started with zero samples");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !cmd.emit)
    else $error("output register overwritten while held");
`endif

endmodule

/* rtl/psk_sine_modulator.sv */
`timescale 1ns / 1ps
// PSK sine modulator top level: configuration registers, controller and datapath.
// Depends on psm_pkg, psm_ctrl and psm_datapath.
// An accepted item loads the phase accumulator and sample counter; its first sample is then
// registered at the output once free. Throughput: one sample per cycle while unstalled;
// a symbol-producing item yields N samples (N = effective samples per symbol, 1..MAX_SAMPLES),
// set by the sample counter, before the next is taken. A QPSK first bit is held and produces nothing.
// Reset (synchronous): BPSK mode, 64 samples per symbol, step 2048, no bit held, output empty.
module psk_sine_modulator #(
  parameter int MAX_SAMPLES     = 64,
  parameter int PHASE_BITS      = 16,
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           bit_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_BITS-1:0]  sample,
  output logic                           last_of_symbol,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [psm_pkg::IDX_W-1:0]      cfg_index,
  input  logic [psm_pkg::STEP_W-1:0]     cfg_data
);

  logic                           mode_qpsk;
  logic [psm_pkg::SPS_W-1:0]      samples_per_symbol;
  logic [psm_pkg::STEP_W-1:0]     phase_step;
  psm_pkg::psm_cmd_t              cmd;
  psm_pkg::psm_status_t           status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_qpsk          <= 1'b0;
      samples_per_symbol <= psm_pkg::SPS_RESET;
      phase_step         <= psm_pkg::STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        psm_pkg::REG_MODE_QPSK: mode_qpsk          <= cfg_data[0];
        psm_pkg::REG_SPS:       samples_per_symbol <= cfg_data[psm_pkg::SPS_W-1:0];
        psm_pkg::REG_STEP:      phase_step         <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  psm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .bit_in    (bit_in),
    .mode_qpsk (mode_qpsk),
    .status    (status),
    .cmd       (cmd)
  );

  psm_datapath #(
    .MAX_SAMPLES     (MAX_SAMPLES),
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .samples_per_symbol (samples_per_symbol),
    .phase_step         (phase_step),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .sample             (sample),
    .last_of_symbol     (last_of_symbol)
  );

`ifndef SYNTH
  a_bpsk_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !mode_qpsk) |=> in_stall)
    else $error("new transaction accepted while a symbol is in progress");
  a_stop_after_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && status.last) |=> !cmd.emit)
    else $error("sample emitted past the end of a symbol");
  a_load_exclusive: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !cmd.emit)
    else $error("symbol load and sample emit in the same cycle");
`endif

endmodule

/* sim/psm_sample_checker.sv */
`timescale 1ns / 1ps
// Sample checker for the PSK sine modulator: watches the bit, sample and register
// channels, works out every carrier sample and compares it. Depends on psm_pkg.
module psm_sample_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          bit_in,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [15:0]            sample,
  input  logic                          last_of_symbol,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [psm_pkg::IDX_W-1:0]     cfg_index,
  input  logic [psm_pkg::STEP_W-1:0]    cfg_data,
  output int                            mismatches,
  output int                            pending,
  output int                            checked
);

  localparam int unsigned      SYMBOL_MAX = 64;
  localparam int               FIFO_DEPTH = 128;
  localparam longint unsigned  ONE_FX     = 64'd1 << 30;
  localparam longint unsigned  QUARTER_FX = 64'd1686629713;
  localparam longint unsigned  PEAK       = 64'd32767;

  typedef struct packed {
    logic [15:0] value;
    logic        last;
  } carrier_sample_t;

  logic signed [15:0] sine_tab [0:1023];
  carrier_sample_t    carrier_fifo [0:FIFO_DEPTH-1];
  logic [6:0]         wr_ptr     = '0;
  logic [6:0]         rd_ptr     = '0;
  int                 fifo_count = 0;

  logic               qpsk_mode;
  logic [6:0]         symbol_len;
  logic [15:0]        step_size;
  logic               held_bit;
  logic               held_valid;
  int                 n_bad     = 0;
  int                 n_checked = 0;

  function automatic longint unsigned series_step(longint unsigned sq, longint unsigned t,
                                                  longint unsigned den);
    longint unsigned sub;
    sub = ((sq * t) >> 30) / den;
    return (sub > ONE_FX) ? 64'd0 : (ONE_FX - sub);
  endfunction

  // Quarter-wave symmetry: odd quadrants read the cosine series, upper half negates
  function automatic logic signed [15:0] sine_entry(int unsigned k);
    logic [1:0]         quad;
    longint unsigned    ang;
    longint unsigned    sq;
    longint unsigned    t;
    longint unsigned    v;
    longint unsigned    mag;
    logic signed [15:0] val;
    quad = k[9:8];
    ang  = (longint'(k & 255) * QUARTER_FX) >> 8;
    sq   = (ang * ang) >> 30;
    t    = ONE_FX;
    if (quad[0]) begin
      t = series_step(sq, t, 182);
      t = series_step(sq, t, 132);
      t = series_step(sq, t, 90);
      t = series_step(sq, t, 56);
      t = series_step(sq, t, 30);
      t = series_step(sq, t, 12);
      t = series_step(sq, t, 2);
      v = t;
    end else begin
      t = series_step(sq, t, 156);
      t = series_step(sq, t, 110);
      t = series_step(sq, t, 72);
      t = series_step(sq, t, 42);
      t = series_step(sq, t, 20);
      t = series_step(sq, t, 6);
      v = (ang * t) >> 30;
    end
    mag = (v * PEAK + (64'd1 << 29)) >> 30;
    if (mag > PEAK) begin
      mag = PEAK;
    end
    val = mag[15:0];
    return quad[1] ? -val : val;
  endfunction

  initial begin
    for (int k = 0; k < 1024; k++) begin
      sine_tab[k] = sine_entry(k);
    end
  end

  task automatic emit_carrier(input logic [1:0] quarter);
    int unsigned     count;
    logic [15:0]     acc;
    carrier_sample_t s;
    count = 32'(symbol_len);
    if (count < 1) begin
      count = 1;
    end
    if (count > SYMBOL_MAX) begin
      count = SYMBOL_MAX;
    end
    acc = {quarter, 14'd0};
    for (int unsigned n = 0; n < count; n++) begin
      s.value = sine_tab[acc[15:6]];
      s.last  = (n + 1 == count);
      carrier_fifo[wr_ptr] = s;
      wr_ptr = wr_ptr + 7'd1;
      fifo_count++;
      acc = acc + step_size;
    end
  endtask

  task automatic take_bit(input logic b);
    if (!qpsk_mode) begin
      held_valid = 1'b0;
      emit_carrier(b ? psm_pkg::PH_PI : psm_pkg::PH_ZERO);
    end else if (!held_valid) begin
      held_bit   = b;
      held_valid = 1'b1;
    end else begin
      held_valid = 1'b0;
      if (!held_bit) begin
        emit_carrier(b ? psm_pkg::PH_PI : psm_pkg::PH_ZERO);
      end else begin
        emit_carrier(b ? psm_pkg::PH_HALF_PI : psm_pkg::PH_THREE_HALF);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    carrier_sample_t want;
    if (rst) begin
      qpsk_mode  = 1'b0;
      symbol_len = psm_pkg::SPS_RESET;
      step_size  = psm_pkg::STEP_RESET;
      held_bit   = 1'b0;
      held_valid = 1'b0;
      wr_ptr     = '0;
      rd_ptr     = '0;
      fifo_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_checked++;
        if (fifo_count == 0) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("%0t: unexpected sample %0d last %0b", $time, sample, last_of_symbol);
          end
        end else begin
          want   = carrier_fifo[rd_ptr];
          rd_ptr = rd_ptr + 7'd1;
          fifo_count--;
          if (sample !== want.value || last_of_symbol !== want.last) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("%0t: sample mismatch: expected %0d last %0b, got %0d last %0b",
                       $time, $signed(want.value), want.last, sample, last_of_symbol);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          psm_pkg::REG_MODE_QPSK: qpsk_mode  = cfg_data[0];
          psm_pkg::REG_SPS:       symbol_len = cfg_data[psm_pkg::SPS_W-1:0];
          psm_pkg::REG_STEP:      step_size  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        take_bit(bit_in);
      end
    end
    mismatches <= n_bad;
    pending    <= fifo_count;
    checked    <= n_checked;
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// Testbench top for the PSK sine modulator: clock, reset, bit stimulus, register
// writes and output stall. Depends on psm_pkg, psk_sine_modulator and psm_sample_checker.
module tb;

  localparam int                        ITEMS     = 370;
  localparam logic [psm_pkg::IDX_W-1:0] REG_SPARE = 2'd3;

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         in_valid  = 1'b0;
  logic                         in_stall;
  logic                         bit_in    = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [15:0]           sample;
  logic                         last_of_symbol;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [psm_pkg::IDX_W-1:0]    cfg_index = '0;
  logic [psm_pkg::STEP_W-1:0]   cfg_data  = '0;

  int                 mismatches;
  int                 pending;
  int                 checked;
  int                 n_bits    = 0;
  int                 n_writes  = 0;
  int                 stall_left = 0;
  bit                 quiet     = 1'b0;

  always #1 clk = ~clk;

  psk_sine_modulator dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .bit_in         (bit_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sample         (sample),
    .last_of_symbol (last_of_symbol),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  psm_sample_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .bit_in         (bit_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sample         (sample),
    .last_of_symbol (last_of_symbol),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .pending        (pending),
    .checked        (checked)
  );

  // Hold stall in runs: mostly short, now and then long
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= ($urandom_range(0, 2) == 0);
      stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
    end
  end

  function automatic int pick_gap();
    if (quiet) begin
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(6, 30);
    end
    return $urandom_range(0, 2);
  endfunction

  task automatic send_bit(input logic b);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    bit_in   <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_bits++;
  endtask

  task automatic write_reg(input logic [psm_pkg::IDX_W-1:0] idx,
                           input logic [psm_pkg::STEP_W-1:0] data, input bit done);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    n_writes++;
    if (done) begin
      cfg_valid <= 1'b0;
    end
  endtask

  // Upper bits of the mode and count words are random and must be dropped
  task automatic set_config(input logic mode, input logic [6:0] len, input logic [15:0] step);
    logic [15:0] w;
    w    = 16'($urandom);
    w[0] = mode;
    write_reg(psm_pkg::REG_MODE_QPSK, w, 1'b0);
    w      = 16'($urandom);
    w[6:0] = len;
    write_reg(psm_pkg::REG_SPS, w, 1'b0);
    write_reg(psm_pkg::REG_STEP, step, 1'b1);
  endtask

  task automatic set_mode(input logic mode);
    logic [15:0] w;
    w    = 16'($urandom);
    w[0] = mode;
    write_reg(psm_pkg::REG_MODE_QPSK, w, 1'b1);
  endtask

  // Wait for every expected sample, then let the block settle
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int          phase;
    int          len;
    int          pause_at;
    logic        mode;
    logic [6:0]  sps;
    logic [15:0] step;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: BPSK, full-length symbols
    send_bit(1'b0);
    send_bit(1'b1);
    wait_drain();

    // every QPSK pair, one sample, flat phase
    set_config(1'b1, 7'd1, 16'd0);
    send_bit(1'b0); send_bit(1'b0);
    send_bit(1'b0); send_bit(1'b1);
    send_bit(1'b1); send_bit(1'b0);
    send_bit(1'b1); send_bit(1'b1);
    wait_drain();

    set_config(1'b1, 7'd64, 16'hFFFF);
    send_bit(1'b1); send_bit(1'b1);
    send_bit(1'b1); send_bit(1'b0);
    wait_drain();

    // zero count acts as one, counts above the maximum clip
    set_config(1'b0, 7'd0, 16'h4000);
    send_bit(1'b1);
    send_bit(1'b0);
    wait_drain();
    set_config(1'b0, 7'd127, 16'h0001);
    send_bit(1'b1);
    wait_drain();

    // spare register index is ignored
    write_reg(REG_SPARE, 16'hFFFF, 1'b1);
    send_bit(1'b0);
    wait_drain();

    // held bit dropped by a BPSK bit
    set_config(1'b1, 7'd5, 16'h1000);
    send_bit(1'b1);
    wait_drain();
    set_mode(1'b0);
    send_bit(1'b0);
    wait_drain();

    // held bit survives a mode toggle and pairs on return to QPSK
    set_mode(1'b1);
    send_bit(1'b1);
    wait_drain();
    set_mode(1'b0);
    @(posedge clk);
    set_mode(1'b1);
    send_bit(1'b0);
    wait_drain();

    phase = 0;
    while (n_bits < ITEMS) begin
      case (phase)
        0: begin mode = 1'b0; sps = 7'd1;   step = 16'd0;     end
        1: begin mode = 1'b1; sps = 7'd64;  step = 16'hFFFF;  end
        2: begin mode = 1'b1; sps = 7'd0;   step = 16'h8000;  end
        3: begin mode = 1'b0; sps = 7'd127; step = 16'h0001;  end
        default: begin
          mode = 1'($urandom_range(0, 1));
          sps  = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                             : 7'($urandom_range(1, 16));
          step = 16'($urandom);
        end
      endcase
      set_config(mode, sps, step);
      quiet    <= ($urandom_range(0, 3) == 0);
      len      = $urandom_range(20, 45);
      pause_at = $urandom_range(5, len - 5);
      for (int k = 0; k < len; k++) begin
        if (k == pause_at) begin
          wait_drain();
        end
        send_bit(1'($urandom_range(0, 1)));
      end
      wait_drain();
      phase++;
    end

    in_valid <= 1'b0;
    repeat (8) @(posedge clk);
    $display("Sent %0d bits over %0d register writes in %0d random phases; %0d samples checked",
             n_bits, n_writes, phase, checked);
    $display("BPSK and QPSK symbols with clipped, zero and extreme counts and steps; %0d awaited",
             pending);
    if (mismatches == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
